@@ design/i2crts_pkg.sv @@
`default_nettype none
package i2crts_pkg;

    localparam int LENGTH_BITS_DEFAULT = 16;
    localparam int WAIT_BITS = 16;
    localparam logic [WAIT_BITS-1:0] WAIT_LIMIT_RESET = 16'd50000;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } command_t;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_WAIT_FREE  = 4'd1,
        PH_WAIT_SB    = 4'd2,
        PH_WAIT_ADDR  = 4'd3,
        PH_WAIT_REG   = 4'd4,
        PH_WAIT_TXE   = 4'd5,
        PH_WAIT_BTF   = 4'd6,
        PH_WAIT_SB2   = 4'd7,
        PH_WAIT_ADDR2 = 4'd8,
        PH_WAIT_RX    = 4'd9
    } phase_t;

    typedef struct packed {
        command_t    command;
        logic [6:0]  dev_addr;
        logic [7:0]  reg_addr;
        logic [15:0] length;
        logic [7:0]  data_byte;
        logic        bus_busy;
        logic        start_done;
        logic        addr_ack;
        logic        addr_nack;
        logic        tx_empty;
        logic        transfer_finished;
        logic        rx_ready;
    } in_item_t;

    typedef struct packed {
        logic       gen_start;
        logic       gen_stop;
        logic       ack_enable;
        logic       clear_nack;
        logic       tx_load;
        logic [7:0] tx_byte;
        logic       payload_taken;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       error;
        logic       busy_res;
    } res_item_t;

endpackage
`default_nettype wire

@@ design/i2crts_ctrl.sv @@
`default_nettype none
module i2crts_ctrl
    import i2crts_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 step,
    input  wire in_item_t             item,
    input  wire logic [WAIT_BITS-1:0] wait_limit,
    output res_item_t                 res
);

    phase_t                 phase_reg, phase_next;
    logic [WAIT_BITS-1:0]   wait_count_reg, wait_count_next;
    logic [LENGTH_BITS-1:0] byte_count_reg, byte_count_next;
    logic [6:0]             dev_addr_reg, dev_addr_next;
    logic [7:0]             reg_addr_reg, reg_addr_next;
    logic [LENGTH_BITS-1:0] length_reg, length_next;
    logic                   is_read_reg, is_read_next;

    logic [WAIT_BITS-1:0]   wc_inc;
    logic                   wait_over;
    logic                   expired;
    logic [LENGTH_BITS:0]   bc_inc;
    logic [LENGTH_BITS+1:0] bc_inc2;
    logic [LENGTH_BITS:0]   len_ext;

    assign wc_inc    = wait_count_reg + 1'b1;
    assign wait_over = (wc_inc >= wait_limit);
    assign bc_inc    = {1'b0, byte_count_reg} + 1'b1;
    assign bc_inc2   = {1'b0, bc_inc} + 1'b1;
    assign len_ext   = {1'b0, length_reg};

    always_comb begin
        phase_next      = phase_reg;
        wait_count_next = wait_count_reg;
        byte_count_next = byte_count_reg;
        dev_addr_next   = dev_addr_reg;
        reg_addr_next   = reg_addr_reg;
        length_next     = length_reg;
        is_read_next    = is_read_reg;
        expired         = 1'b0;
        res             = '0;

        unique case (phase_reg)
            PH_IDLE: begin
                if (item.command == CMD_WRITE || item.command == CMD_READ) begin
                    dev_addr_next   = item.dev_addr;
                    reg_addr_next   = item.reg_addr;
                    length_next     = item.length[LENGTH_BITS-1:0];
                    is_read_next    = (item.command == CMD_READ);
                    byte_count_next = '0;
                    phase_next      = PH_WAIT_FREE;
                    wait_count_next = '0;
                end
            end
            PH_WAIT_FREE: begin
                if (!item.bus_busy) begin
                    res.gen_start   = 1'b1;
                    phase_next      = PH_WAIT_SB;
                    wait_count_next = '0;
                end else begin
                    wait_count_next = wc_inc;
                    expired         = wait_over;
                end
            end
            PH_WAIT_SB, PH_WAIT_SB2: begin
                if (item.start_done) begin
                    res.tx_load     = 1'b1;
                    res.tx_byte     = {dev_addr_reg, phase_reg == PH_WAIT_SB2};
                    phase_next      = (phase_reg == PH_WAIT_SB2) ? PH_WAIT_ADDR2 : PH_WAIT_ADDR;
                    wait_count_next = '0;
                end else begin
                    wait_count_next = wc_inc;
                    expired         = wait_over;
                end
            end
            PH_WAIT_ADDR, PH_WAIT_ADDR2: begin
                // nack wins over ack
                if (item.addr_nack) begin
                    res.clear_nack  = 1'b1;
                    res.gen_stop    = 1'b1;
                    res.error       = 1'b1;
                    phase_next      = PH_IDLE;
                    wait_count_next = '0;
                end else if (item.addr_ack) begin
                    wait_count_next = '0;
                    if (phase_reg == PH_WAIT_ADDR) begin
                        res.tx_load = 1'b1;
                        res.tx_byte = reg_addr_reg;
                        phase_next  = PH_WAIT_REG;
                    end else if (length_reg == '0) begin
                        res.gen_stop = 1'b1;
                        res.done_res = 1'b1;
                        phase_next   = PH_IDLE;
                    end else begin
                        byte_count_next = '0;
                        if (len_ext == 1) begin
                            res.gen_stop = 1'b1;
                        end else begin
                            res.ack_enable = 1'b1;
                        end
                        phase_next = PH_WAIT_RX;
                    end
                end else begin
                    wait_count_next = wc_inc;
                    expired         = wait_over;
                end
            end
            PH_WAIT_REG: begin
                if (item.tx_empty) begin
                    wait_count_next = '0;
                    if (is_read_reg) begin
                        res.gen_start = 1'b1;
                        phase_next    = PH_WAIT_SB2;
                    end else if (length_reg == '0) begin
                        phase_next = PH_WAIT_BTF;
                    end else begin
                        res.tx_load       = 1'b1;
                        res.tx_byte       = item.data_byte;
                        res.payload_taken = 1'b1;
                        byte_count_next   = {{(LENGTH_BITS-1){1'b0}}, 1'b1};
                        phase_next        = PH_WAIT_TXE;
                    end
                end else begin
                    wait_count_next = wc_inc;
                    expired         = wait_over;
                end
            end
            PH_WAIT_TXE: begin
                if (item.tx_empty) begin
                    wait_count_next = '0;
                    if (byte_count_reg >= length_reg) begin
                        phase_next = PH_WAIT_BTF;
                    end else begin
                        res.tx_load       = 1'b1;
                        res.tx_byte       = item.data_byte;
                        res.payload_taken = 1'b1;
                        byte_count_next   = bc_inc[LENGTH_BITS-1:0];
                    end
                end else begin
                    wait_count_next = wc_inc;
                    expired         = wait_over;
                end
            end
            PH_WAIT_BTF: begin
                if (item.transfer_finished) begin
                    res.gen_stop    = 1'b1;
                    res.done_res    = 1'b1;
                    phase_next      = PH_IDLE;
                    wait_count_next = '0;
                end else begin
                    wait_count_next = wc_inc;
                    expired         = wait_over;
                end
            end
            PH_WAIT_RX: begin
                if (item.rx_ready) begin
                    res.rx_valid    = 1'b1;
                    res.rx_byte     = item.data_byte;
                    byte_count_next = bc_inc[LENGTH_BITS-1:0];
                    wait_count_next = '0;
                    if (bc_inc >= len_ext) begin
                        res.done_res = 1'b1;
                        phase_next   = PH_IDLE;
                    end else if (bc_inc2 == {1'b0, len_ext}) begin
                        res.gen_stop = 1'b1;
                    end else begin
                        res.ack_enable = 1'b1;
                    end
                end else begin
                    wait_count_next = wc_inc;
                    expired         = wait_over;
                    // keep acking while more than one byte is still due
                    if (!wait_over && bc_inc < len_ext) begin
                        res.ack_enable = 1'b1;
                    end
                end
            end
            default: begin
                phase_next      = PH_IDLE;
                wait_count_next = '0;
            end
        endcase

        if (expired) begin
            res.error       = 1'b1;
            res.ack_enable  = 1'b0;
            phase_next      = PH_IDLE;
            wait_count_next = '0;
        end

        res.busy_res = (phase_next != PH_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            wait_count_reg <= '0;
            byte_count_reg <= '0;
            dev_addr_reg   <= '0;
            reg_addr_reg   <= '0;
            length_reg     <= '0;
            is_read_reg    <= 1'b0;
        end else if (step) begin
            phase_reg      <= phase_next;
            wait_count_reg <= wait_count_next;
            byte_count_reg <= byte_count_next;
            dev_addr_reg   <= dev_addr_next;
            reg_addr_reg   <= reg_addr_next;
            length_reg     <= length_next;
            is_read_reg    <= is_read_next;
        end
    end

endmodule
`default_nettype wire

@@ design/i2c_register_transaction_sequencer.sv @@
`default_nettype none
// one result item per input item; m_tvalid rises in the cycle after the accept
// throughput one item per cycle while m_tready stays high; the sequencer step plus the output register set it
// s_tready drops only while a result waits and m_tready is low
// synchronous active-low reset: sequencer idle, counters cleared, wait_limit = 50000
module i2c_register_transaction_sequencer
    import i2crts_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [WAIT_BITS-1:0] cfg_wr_data,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // dev_addr, reg_addr, length, data_byte, bus_busy, start_done, addr_ack,
    // addr_nack, tx_empty, transfer_finished, rx_ready, zero pad
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // command
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // gen_start, gen_stop, ack_enable, clear_nack, tx_load, tx_byte, payload_taken,
    // rx_valid, rx_byte, done_res, error, busy_res, zero pad
    output logic [M_TDATA_W-1:0]      m_tdata
);

    logic [WAIT_BITS-1:0] wait_limit_reg;
    logic                 m_valid_reg;
    res_item_t            res_reg;
    in_item_t             item;
    res_item_t            res;
    logic                 accept;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign item.command           = command_t'(s_tuser);
    assign item.dev_addr          = s_tdata[6:0];
    assign item.reg_addr          = s_tdata[14:7];
    assign item.length            = s_tdata[30:15];
    assign item.data_byte         = s_tdata[38:31];
    assign item.bus_busy          = s_tdata[39];
    assign item.start_done        = s_tdata[40];
    assign item.addr_ack          = s_tdata[41];
    assign item.addr_nack         = s_tdata[42];
    assign item.tx_empty          = s_tdata[43];
    assign item.transfer_finished = s_tdata[44];
    assign item.rx_ready          = s_tdata[45];

    i2crts_ctrl #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (accept),
        .item       (item),
        .wait_limit (wait_limit_reg),
        .res        (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wait_limit_reg <= WAIT_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            wait_limit_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_tready) begin
            m_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0,
                       res_reg.busy_res,
                       res_reg.error,
                       res_reg.done_res,
                       res_reg.rx_byte,
                       res_reg.rx_valid,
                       res_reg.payload_taken,
                       res_reg.tx_byte,
                       res_reg.tx_load,
                       res_reg.clear_nack,
                       res_reg.ack_enable,
                       res_reg.gen_stop,
                       res_reg.gen_start};

endmodule
`default_nettype wire

@@ bench/i2c_register_transaction_sequencer_tb.sv @@
`default_nettype none
module i2c_register_transaction_sequencer_tb;
    import i2crts_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 244;
    localparam int MAX_PRINTED = 40;

    // engine status flags for the directed rows, {busy, sb, ack, nack, txe, btf, rxne}
    localparam logic [6:0] F_NONE = 7'b0000000;
    localparam logic [6:0] F_BUSY = 7'b1000000;
    localparam logic [6:0] F_SB   = 7'b0100000;
    localparam logic [6:0] F_ACK  = 7'b0010000;
    localparam logic [6:0] F_NACK = 7'b0001000;
    localparam logic [6:0] F_TXE  = 7'b0000100;
    localparam logic [6:0] F_BTF  = 7'b0000010;
    localparam logic [6:0] F_ALL  = 7'b1111111;

    typedef struct {
        in_item_t  item;
        bit        typed;
        res_item_t want;
    } dir_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [WAIT_BITS-1:0] cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    i2c_register_transaction_sequencer dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // predicted sequencer state
    phase_t      seq_ph;
    logic [15:0] seq_wait;
    logic [15:0] seq_bytes;
    logic [6:0]  seq_dev;
    logic [7:0]  seq_reg;
    logic [15:0] seq_len;
    logic        seq_rd;
    logic [15:0] seq_limit;

    res_item_t expected_bus_actions[$];
    dir_row_t  directed_rows[$];

    int gap_pct;
    int stall_pct;
    int n_fail;
    int n_sent;
    int n_checked;
    int n_done;
    int n_aborted;
    int n_read_bytes;
    int n_written_bytes;
    int cycle_count;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still awaited",
                     cycle_count, expected_bus_actions.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic in_item_t status_item(command_t cmd, logic [6:0] dev, logic [7:0] rg,
                                             logic [15:0] len, logic [7:0] data,
                                             logic [6:0] flags);
        in_item_t it;
        it.command = cmd;
        it.dev_addr = dev;
        it.reg_addr = rg;
        it.length = len;
        it.data_byte = data;
        {it.bus_busy, it.start_done, it.addr_ack, it.addr_nack, it.tx_empty,
         it.transfer_finished, it.rx_ready} = flags;
        return it;
    endfunction

    function automatic void add_row(in_item_t it, bit typed, res_item_t want);
        dir_row_t row;
        row.item = it;
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_status(in_item_t it);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[6:0] = it.dev_addr;
        d[14:7] = it.reg_addr;
        d[30:15] = it.length;
        d[38:31] = it.data_byte;
        d[39] = it.bus_busy;
        d[40] = it.start_done;
        d[41] = it.addr_ack;
        d[42] = it.addr_nack;
        d[43] = it.tx_empty;
        d[44] = it.transfer_finished;
        d[45] = it.rx_ready;
        return d;
    endfunction

    function automatic res_item_t unpack_actions(logic [M_TDATA_W-1:0] d);
        res_item_t r;
        r.gen_start = d[0];
        r.gen_stop = d[1];
        r.ack_enable = d[2];
        r.clear_nack = d[3];
        r.tx_load = d[4];
        r.tx_byte = d[12:5];
        r.payload_taken = d[13];
        r.rx_valid = d[14];
        r.rx_byte = d[22:15];
        r.done_res = d[23];
        r.error = d[24];
        r.busy_res = d[25];
        return r;
    endfunction

    function automatic void step_to(phase_t next);
        seq_ph = next;
        seq_wait = '0;
    endfunction

    // one more failed check; true once the wait has run out
    function automatic bit wait_expired();
        seq_wait = seq_wait + 16'd1;
        return seq_wait >= seq_limit;
    endfunction

    function automatic res_item_t predict_bus_step(in_item_t it);
        res_item_t r;
        logic expired;
        r = '0;
        expired = 1'b0;
        case (seq_ph)
            PH_IDLE: begin
                if (it.command == CMD_WRITE || it.command == CMD_READ) begin
                    seq_dev = it.dev_addr;
                    seq_reg = it.reg_addr;
                    seq_len = it.length;
                    seq_rd = (it.command == CMD_READ);
                    seq_bytes = '0;
                    step_to(PH_WAIT_FREE);
                end
            end
            PH_WAIT_FREE: begin
                if (!it.bus_busy) begin
                    r.gen_start = 1'b1;
                    step_to(PH_WAIT_SB);
                end else expired = wait_expired();
            end
            PH_WAIT_SB, PH_WAIT_SB2: begin
                if (it.start_done) begin
                    r.tx_load = 1'b1;
                    r.tx_byte = {seq_dev, seq_ph == PH_WAIT_SB2};
                    step_to(seq_ph == PH_WAIT_SB2 ? PH_WAIT_ADDR2 : PH_WAIT_ADDR);
                end else expired = wait_expired();
            end
            PH_WAIT_ADDR, PH_WAIT_ADDR2: begin
                if (it.addr_nack) begin
                    r.clear_nack = 1'b1;
                    r.gen_stop = 1'b1;
                    r.error = 1'b1;
                    step_to(PH_IDLE);
                end else if (it.addr_ack) begin
                    if (seq_ph == PH_WAIT_ADDR) begin
                        r.tx_load = 1'b1;
                        r.tx_byte = seq_reg;
                        step_to(PH_WAIT_REG);
                    end else if (seq_len == 16'd0) begin
                        r.gen_stop = 1'b1;
                        r.done_res = 1'b1;
                        step_to(PH_IDLE);
                    end else begin
                        seq_bytes = '0;
                        if (seq_len == 16'd1) r.gen_stop = 1'b1;
                        else r.ack_enable = 1'b1;
                        step_to(PH_WAIT_RX);
                    end
                end else expired = wait_expired();
            end
            PH_WAIT_REG: begin
                if (it.tx_empty) begin
                    if (seq_rd) begin
                        r.gen_start = 1'b1;
                        step_to(PH_WAIT_SB2);
                    end else if (seq_len == 16'd0) begin
                        step_to(PH_WAIT_BTF);
                    end else begin
                        r.tx_load = 1'b1;
                        r.tx_byte = it.data_byte;
                        r.payload_taken = 1'b1;
                        seq_bytes = 16'd1;
                        step_to(PH_WAIT_TXE);
                    end
                end else expired = wait_expired();
            end
            PH_WAIT_TXE: begin
                if (it.tx_empty) begin
                    if (seq_bytes >= seq_len) begin
                        step_to(PH_WAIT_BTF);
                    end else begin
                        r.tx_load = 1'b1;
                        r.tx_byte = it.data_byte;
                        r.payload_taken = 1'b1;
                        seq_bytes = seq_bytes + 16'd1;
                        step_to(PH_WAIT_TXE);
                    end
                end else expired = wait_expired();
            end
            PH_WAIT_BTF: begin
                if (it.transfer_finished) begin
                    r.gen_stop = 1'b1;
                    r.done_res = 1'b1;
                    step_to(PH_IDLE);
                end else expired = wait_expired();
            end
            PH_WAIT_RX: begin
                if (it.rx_ready) begin
                    r.rx_valid = 1'b1;
                    r.rx_byte = it.data_byte;
                    seq_bytes = seq_bytes + 16'd1;
                    if (seq_bytes >= seq_len) begin
                        r.done_res = 1'b1;
                        step_to(PH_IDLE);
                    end else begin
                        // nack goes out with the last byte
                        if ({1'b0, seq_bytes} + 17'd1 == {1'b0, seq_len}) r.gen_stop = 1'b1;
                        else r.ack_enable = 1'b1;
                        step_to(PH_WAIT_RX);
                    end
                end else begin
                    expired = wait_expired();
                    if (!expired && ({1'b0, seq_bytes} + 17'd1 < {1'b0, seq_len}))
                        r.ack_enable = 1'b1;
                end
            end
            default: step_to(PH_IDLE);
        endcase
        if (expired) begin
            r.error = 1'b1;
            r.ack_enable = 1'b0;
            step_to(PH_IDLE);
        end
        r.busy_res = (seq_ph != PH_IDLE);
        return r;
    endfunction

    function automatic logic [15:0] pick_length();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 25) return 16'd0;
        if (roll < 85) return 16'($urandom_range(4, 1));
        // very long transfers only where a short wait limit can cut them off
        if (roll < 95 || seq_limit > 16'd64) return 16'($urandom_range(20, 5));
        return 16'($urandom);
    endfunction

    // mostly well-formed engine responses for the current step, some plain noise
    function automatic in_item_t next_tick_item();
        in_item_t it;
        logic [63:0] raw;
        bit go;
        raw = {$urandom, $urandom};
        it = raw[$bits(in_item_t)-1:0];
        if (seq_ph == PH_IDLE && seq_limit > 16'd64) it.length = it.length & 16'h001F;
        if ($urandom_range(99) < 15) return it;
        it.command = CMD_TICK;
        if (seq_ph == PH_IDLE) begin
            if ($urandom_range(9) < 6) begin
                it.command = $urandom_range(1) ? CMD_READ : CMD_WRITE;
                it.length = pick_length();
            end
        end else if ($urandom_range(19) == 0) begin
            it.command = command_t'($urandom_range(3, 1));
        end
        go = ($urandom_range(99) < 75);
        if (seq_len > 16'd24 && seq_bytes >= 16'd6 &&
            (seq_ph == PH_WAIT_TXE || seq_ph == PH_WAIT_RX))
            go = 1'b0;
        case (seq_ph)
            PH_WAIT_FREE: it.bus_busy = !go;
            PH_WAIT_SB, PH_WAIT_SB2: it.start_done = go;
            PH_WAIT_ADDR, PH_WAIT_ADDR2: begin
                it.addr_ack = go;
                it.addr_nack = go && ($urandom_range(9) == 0);
            end
            PH_WAIT_REG, PH_WAIT_TXE: it.tx_empty = go;
            PH_WAIT_BTF: it.transfer_finished = go;
            PH_WAIT_RX: it.rx_ready = go;
            default: ;
        endcase
        return it;
    endfunction

    task automatic send_item(in_item_t it, bit typed, res_item_t want);
        res_item_t predicted;
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        predicted = predict_bus_step(it);
        expected_bus_actions.push_back(typed ? want : predicted);
        s_tvalid <= 1'b1;
        s_tdata <= pack_status(it);
        s_tuser <= it.command;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n_sent++;
        @(negedge aclk);
    endtask

    task automatic write_wait_limit(logic [15:0] value);
        s_tvalid <= 1'b0;
        while (expected_bus_actions.size() != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        seq_limit = value;
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            n_fail++;
            if (n_fail <= MAX_PRINTED)
                $display("%0t: result %0d field %s expected 0x%0h actual 0x%0h",
                         $time, n_checked, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        res_item_t got;
        res_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = unpack_actions(m_tdata);
            if (expected_bus_actions.size() == 0) begin
                n_fail++;
                if (n_fail <= MAX_PRINTED)
                    $display("%0t: result with nothing expected, actual 0x%0h",
                             $time, m_tdata);
            end else begin
                want = expected_bus_actions.pop_front();
                check_field("gen_start", want.gen_start, got.gen_start);
                check_field("gen_stop", want.gen_stop, got.gen_stop);
                check_field("ack_enable", want.ack_enable, got.ack_enable);
                check_field("clear_nack", want.clear_nack, got.clear_nack);
                check_field("tx_load", want.tx_load, got.tx_load);
                check_field("tx_byte", want.tx_byte, got.tx_byte);
                check_field("payload_taken", want.payload_taken, got.payload_taken);
                check_field("rx_valid", want.rx_valid, got.rx_valid);
                check_field("rx_byte", want.rx_byte, got.rx_byte);
                check_field("done_res", want.done_res, got.done_res);
                check_field("error", want.error, got.error);
                check_field("busy_res", want.busy_res, got.busy_res);
                n_checked++;
            end
            n_done += got.done_res;
            n_aborted += got.error;
            n_read_bytes += got.rx_valid;
            n_written_bytes += got.payload_taken;
        end
    end

    initial begin
        m_tready = 1'b1;
        forever begin
            @(negedge aclk);
            m_tready <= ($urandom_range(99) < stall_pct) ? 1'b0 : 1'b1;
        end
    end

    initial begin
        res_item_t w;
        in_item_t it;
        int counted;
        logic [15:0] lim;

        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        gap_pct = 0;
        stall_pct = 0;
        n_fail = 0;
        n_sent = 0;
        n_checked = 0;
        n_done = 0;
        n_aborted = 0;
        n_read_bytes = 0;
        n_written_bytes = 0;
        cycle_count = 0;

        seq_ph = PH_IDLE;
        seq_wait = '0;
        seq_bytes = '0;
        seq_dev = '0;
        seq_reg = '0;
        seq_len = '0;
        seq_rd = 1'b0;
        seq_limit = WAIT_LIMIT_RESET;

        w = '0;
        // unused code and plain tick leave the idle block alone
        add_row(status_item(CMD_NONE, 7'h7F, 8'hFF, 16'hFFFF, 8'hFF, F_ALL), 1'b1, w);
        add_row(status_item(CMD_TICK, 7'h00, 8'h00, 16'h0000, 8'h00, F_NONE), 1'b1, w);
        w.busy_res = 1'b1;
        add_row(status_item(CMD_WRITE, 7'h7F, 8'hFF, 16'd2, 8'h00, F_BUSY), 1'b1, w);
        add_row(status_item(CMD_TICK, 7'h00, 8'h00, 16'd0, 8'h00, F_NONE), 1'b0, w);
        add_row(status_item(CMD_TICK, 7'h00, 8'h00, 16'd0, 8'h00, F_SB), 1'b0, w);
        // a new request while busy is dropped
        add_row(status_item(CMD_READ, 7'h01, 8'h02, 16'd3, 8'h00, F_ACK), 1'b0, w);
        add_row(status_item(CMD_TICK, 7'h00, 8'h00, 16'd0, 8'hA5, F_TXE), 1'b0, w);
        add_row(status_item(CMD_TICK, 7'h00, 8'h00, 16'd0, 8'h5A, F_TXE), 1'b0, w);
        add_row(status_item(CMD_TICK, 7'h00, 8'h00, 16'd0, 8'hFF, F_TXE), 1'b0, w);
        w = '0;
        w.gen_stop = 1'b1;
        w.done_res = 1'b1;
        add_row(status_item(CMD_TICK, 7'h00, 8'h00, 16'd0, 8'h00, F_BTF), 1'b1, w);
        // zero-length write still waits for the last byte to finish
        add_row(status_item(CMD_WRITE, 7'h00, 8'h00, 16'd0, 8'h00, F_NONE), 1'b0, w);
        add_row(status_item(CMD_TICK, 7'h00, 8'h00, 16'd0, 8'h00, F_NONE), 1'b0, w);
        add_row(status_item(CMD_TICK, 7'h00, 8'h00, 16'd0, 8'h00, F_SB), 1'b0, w);
        add_row(status_item(CMD_TICK, 7'h00, 8'h00, 16'd0, 8'h00, F_ACK), 1'b0, w);
        add_row(status_item(CMD_TICK, 7'h00, 8'h00, 16'd0, 8'h00, F_TXE), 1'b0, w);
        add_row(status_item(CMD_TICK, 7'h00, 8'h00, 16'd0, 8'h00, F_BTF), 1'b1, w);
        // address nack wins over ack
        add_row(status_item(CMD_READ, 7'h55, 8'h3C, 16'hFFFF, 8'h00, F_NONE), 1'b0, w);
        add_row(status_item(CMD_TICK, 7'h00, 8'h00, 16'd0, 8'h00, F_NONE), 1'b0, w);
        add_row(status_item(CMD_TICK, 7'h00, 8'h00, 16'd0, 8'h00, F_SB), 1'b0, w);
        w = '0;
        w.gen_stop = 1'b1;
        w.clear_nack = 1'b1;
        w.error = 1'b1;
        add_row(status_item(CMD_TICK, 7'h00, 8'h00, 16'd0, 8'h00, F_ACK | F_NACK), 1'b1, w);
        // zero-length read ends right after the read address
        add_row(status_item(CMD_READ, 7'h2A, 8'h81, 16'd0, 8'h00, F_NONE), 1'b0, w);
        add_row(status_item(CMD_TICK, 7'h00, 8'h00, 16'd0, 8'h00, F_NONE), 1'b0, w);
        add_row(status_item(CMD_TICK, 7'h00, 8'h00, 16'd0, 8'h00, F_SB), 1'b0, w);
        add_row(status_item(CMD_TICK, 7'h00, 8'h00, 16'd0, 8'h00, F_ACK), 1'b0, w);
        add_row(status_item(CMD_TICK, 7'h00, 8'h00, 16'd0, 8'h00, F_TXE), 1'b0, w);
        add_row(status_item(CMD_TICK, 7'h00, 8'h00, 16'd0, 8'h00, F_SB), 1'b0, w);
        w = '0;
        w.gen_stop = 1'b1;
        w.done_res = 1'b1;
        add_row(status_item(CMD_TICK, 7'h00, 8'h00, 16'd0, 8'h00, F_ACK), 1'b1, w);

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

        w = '0;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: lim = WAIT_LIMIT_RESET;
                1: lim = 16'd1;
                2: lim = 16'd65535;
                3: lim = 16'($urandom_range(12, 2));
                4: lim = 16'($urandom_range(40, 1));
                5: lim = 16'($urandom_range(8, 3));
                6: lim = 16'($urandom_range(65535, 100));
                default: lim = 16'd4;
            endcase
            if (p != 0) write_wait_limit(lim);
            case (p % 4)
                0: begin gap_pct = 0; stall_pct = 0; end
                1: begin gap_pct = 59; stall_pct = 0; end
                2: begin gap_pct = 0; stall_pct = 59; end
                default: begin gap_pct = 24; stall_pct = 24; end
            endcase
            counted = 0;
            while (counted < ITEMS_PER_PHASE) begin
                it = next_tick_item();
                // idle plain ticks change nothing and do not count
                if (seq_ph != PH_IDLE || it.command == CMD_WRITE || it.command == CMD_READ)
                    counted++;
                send_item(it, 1'b0, w);
            end
        end

        s_tvalid <= 1'b0;
        while (expected_bus_actions.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);

        $display("sent %0d items over %0d wait-limit settings, %0d results checked",
                 n_sent, PHASES, n_checked);
        $display("transfers done %0d, ended by error %0d, bytes written %0d, bytes read %0d",
                 n_done, n_aborted, n_written_bytes, n_read_bytes);
        if (n_fail == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", n_fail);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
`default_nettype wire
